FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked implication checks with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at that edge.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, codes and the digit character table for the radix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itra_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int IN_VALUE_W      = 32;
   localparam int FUNC_W          = 2;
   localparam int CHAR_W          = 7;

   typedef enum logic [FUNC_W-1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_DEC = 2'd2,
      RADIX_HEX = 2'd3
   } radix_type;

   typedef logic [CHAR_W-1:0] char_type;

   localparam char_type DIGIT_CHARS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   // Commands from the controller to the datapath; at most one is high.
   typedef struct packed {
      logic load;    // capture a new value and radix
      logic dabble;  // one double-dabble step
      logic trim;    // drop one leading decimal zero
      logic emit;    // move the top digit into the output register
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;  // digit or bit counter at its final step
      logic top_zero;  // current top digit is zero
      logic out_free;  // output register can take a character this cycle
   } status_type;

   function automatic char_type digit_ascii(input logic [3:0] d);
      return DIGIT_CHARS[d];
   endfunction

endpackage

`default_nettype wire

FILE: design/itra_ctrl.sv
// ----------------------------------------------------------------------------
// itra_ctrl
// Sequencer: accept, convert (decimal only), trim leading zeros, send digits.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [itra_pkg::FUNC_W-1:0] req_func,
   output logic                         req_ready,
   input  wire itra_pkg::status_type    sts,
   output itra_pkg::cmd_type            cmd
);
   import itra_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_TRIM = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (radix_type'(req_func) == RADIX_DEC) ? ST_CONV : ST_SEND;
            end
         end
         ST_CONV: begin
            cmd.dabble = 1'b1;
            if (sts.cnt_zero) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // drop leading zeros, keep at least one digit
            if (sts.top_zero && !sts.cnt_zero) begin
               cmd.trim = 1'b1;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.cnt_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/itra_dpath.sv
// ----------------------------------------------------------------------------
// itra_dpath
// Digit shift register, double-dabble BCD register, counter, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_dpath #(
   parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [itra_pkg::IN_VALUE_W-1:0] req_value,
   input  wire logic [itra_pkg::FUNC_W-1:0] req_func,
   input  wire itra_pkg::cmd_type           cmd,
   output itra_pkg::status_type             sts,
   output itra_pkg::char_type               rsp_char,
   output logic                             rsp_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready
);
   import itra_pkg::*;

   localparam int NOCT   = (VALUE_WIDTH + 2) / 3;
   localparam int NHEX   = (VALUE_WIDTH + 3) / 4;
   localparam int SW     = (3 * NOCT > 4 * NHEX) ? 3 * NOCT : 4 * NHEX;
   localparam int ND     = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int BW     = 4 * ND;
   localparam int CW     = $clog2(VALUE_WIDTH);
   localparam int SH_BIN = SW - VALUE_WIDTH;
   localparam int SH_OCT = SW - 3 * NOCT;
   localparam int SH_HEX = SW - 4 * NHEX;

   logic [SW-1:0]          sh_ff, sh_in;
   logic [BW-1:0]          bcd_ff, bcd_in;
   logic [BW-1:0]          bcd_adj;
   logic [CW-1:0]          cnt_ff, cnt_in;
   radix_type              radix_ff, radix_in;
   char_type               char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0] val_w;
   logic [3:0]             top_digit;
   logic                   cnt_zero;

   assign val_w    = VALUE_WIDTH'(req_value);
   assign cnt_zero = (cnt_ff == '0);

   always_comb begin
      unique case (radix_ff)
         RADIX_BIN: top_digit = {3'b000, sh_ff[SW-1]};
         RADIX_OCT: top_digit = {1'b0, sh_ff[SW-1 -: 3]};
         RADIX_DEC: top_digit = bcd_ff[BW-1 -: 4];
         RADIX_HEX: top_digit = sh_ff[SW-1 -: 4];
      endcase
   end

   // add-3 correction on every BCD digit before the shift
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                          : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      sh_in    = sh_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      radix_in = radix_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff & ~rsp_ready;
      if (cmd.load) begin
         radix_in = radix_type'(req_func);
         bcd_in   = '0;
         unique case (radix_type'(req_func))
            RADIX_BIN: begin
               sh_in  = SW'(val_w) << SH_BIN;
               cnt_in = CW'(VALUE_WIDTH - 1);
            end
            RADIX_OCT: begin
               sh_in  = SW'(val_w) << SH_OCT;
               cnt_in = CW'(NOCT - 1);
            end
            RADIX_DEC: begin
               sh_in  = SW'(val_w) << SH_BIN;
               cnt_in = CW'(VALUE_WIDTH - 1);
            end
            RADIX_HEX: begin
               sh_in  = SW'(val_w) << SH_HEX;
               cnt_in = CW'(NHEX - 1);
            end
         endcase
      end else if (cmd.dabble) begin
         bcd_in = {bcd_adj[BW-2:0], sh_ff[SW-1]};
         sh_in  = sh_ff << 1;
         // on the last bit, rearm the counter for the decimal digits
         cnt_in = cnt_zero ? CW'(ND - 1) : cnt_ff - 1'b1;
      end else if (cmd.trim) begin
         bcd_in = bcd_ff << 4;
         cnt_in = cnt_ff - 1'b1;
      end else if (cmd.emit) begin
         char_in  = digit_ascii(top_digit);
         last_in  = cnt_zero;
         valid_in = 1'b1;
         cnt_in   = cnt_ff - 1'b1;
         unique case (radix_ff)
            RADIX_BIN: sh_in  = sh_ff << 1;
            RADIX_OCT: sh_in  = sh_ff << 3;
            RADIX_DEC: bcd_in = bcd_ff << 4;
            RADIX_HEX: sh_in  = sh_ff << 4;
         endcase
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      sh_ff    <= sh_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      if (reset) begin
         radix_ff <= RADIX_BIN;
         valid_ff <= 1'b0;
      end else begin
         radix_ff <= radix_in;
         valid_ff <= valid_in;
      end
   end

   assign sts.cnt_zero = cnt_zero;
   assign sts.top_zero = (top_digit == 4'd0);
   assign sts.out_free = ~valid_ff | rsp_ready;

   assign rsp_char  = char_ff;
   assign rsp_last  = last_ff;
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

FILE: design/integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Unsigned integer to ASCII digit string in binary, octal, decimal or hex.
// ----------------------------------------------------------------------------
// Each input transfer carries an unsigned magnitude and a radix select; the
// block answers with one output transfer per ASCII character, most
// significant digit first, tlast high on the final character. Binary, octal
// and hex give a fixed digit count with leading zeros (VALUE_WIDTH,
// ceil(VALUE_WIDTH/3), ceil(VALUE_WIDTH/4): 32, 11 and 8 at the default
// width); hex letters are uppercase. Decimal gives no leading zeros, and zero
// comes out as the single character "0". The input value is taken modulo
// 2^VALUE_WIDTH. One item is in work at a time: req_tready is high only while
// the sequencer is idle, and the last character may still wait in the output
// register while the next item is taken. With a free-running sink a fixed
// radix item is paced by the one-character output register. A decimal item
// runs the bit-serial double-dabble loop over all VALUE_WIDTH bits, then
// drops leading zeros one digit at a time, then sends the digits. Dropped
// zeros and digits always add up to the ten BCD digits at the default width.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module integer_to_radix_ascii #(
   parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: value [31:0], func [33:32], zero pad [39:34]
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // response: digit_char [6:0], zero pad [7]
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);
   import itra_pkg::*;

   cmd_type    cmd;
   status_type sts;
   char_type   rsp_char;

   // sequencer: owns the accept handshake and the step order
   itra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tdata[IN_VALUE_W +: FUNC_W]),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: shift and BCD registers plus the output register
   itra_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_tdata[IN_VALUE_W-1:0]),
      .req_func  (req_tdata[IN_VALUE_W +: FUNC_W]),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, rsp_char};

   // an accepted item keeps the block busy for at least the next cycle
   `ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready,
      "input accepted again right after a transfer")
   // never overwrite a character that the sink has not taken
   `ASSERT_IMP(a_emit_into_free, clock, reset, cmd.emit, !rsp_tvalid || rsp_tready,
      "character emitted over a pending result")
   // datapath commands are mutually exclusive
   `ASSERT_IMP(a_cmd_exclusive, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.dabble, cmd.trim, cmd.emit}),
      "more than one datapath command at once")

endmodule

`default_nettype wire

FILE: verif/integer_to_radix_ascii_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_test
// Self-checking bench for the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
// A directed burst covers zero, all ones and the top-bit value in every radix,
// plus decimal digit-count boundaries and alternating bit patterns. About 300
// random transfers follow. Each accepted request is spelled out here into its
// expected characters; every response transfer is checked against the oldest
// one. Both sides idle at random, with quiet stretches where they never wait.
// ----------------------------------------------------------------------------

module integer_to_radix_ascii_test;

   import itra_pkg::*;

   localparam int RANDOM_ITEMS = 300;
   localparam int STALL_LIMIT  = 2000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES = 60;     // covers the longest decimal conversion
   localparam int MAX_WAIT     = 14;
   localparam int REPORT_LIMIT = 10;

   localparam char_type ZERO_CHAR   = 7'h30;  // '0'
   localparam char_type LETTER_BASE = 7'h37;  // 'A' minus ten

   typedef struct packed {
      char_type digit_char;
      logic     last;
   } glyph_type;

   // -------------------------------------------------------------------------
   // Scoreboard: spells each accepted value and matches the response stream.
   // -------------------------------------------------------------------------
   class ascii_digit_board;
      glyph_type pending_chars[$];
      int        mismatches;

      function new();
         mismatches = 0;
      endfunction

      function char_type glyph_of(input logic [3:0] d);
         return (d < 4'd10) ? ZERO_CHAR + char_type'(d) : LETTER_BASE + char_type'(d);
      endfunction

      // Work out the digit string for one accepted request, top digit first.
      function void note_request(input logic [31:0] value, input radix_type radix);
         char_type   spelled[$];
         logic [32:0] wide;
         logic [31:0] rest;
         glyph_type  g;
         wide = {1'b0, value};
         rest = value;
         case (radix)
            RADIX_BIN: begin
               for (int b = 31; b >= 0; b--)
                  spelled.push_back(glyph_of({3'b000, value[b]}));
            end
            RADIX_OCT: begin
               // 11 digits; the top one holds only value bits 31:30 with zeros above
               for (int d = 10; d >= 0; d--)
                  spelled.push_back(glyph_of({1'b0, wide[3*d +: 3]}));
            end
            RADIX_HEX: begin
               for (int d = 7; d >= 0; d--)
                  spelled.push_back(glyph_of(value[4*d +: 4]));
            end
            default: begin
               // decimal: collect least significant first, zero still gives "0"
               do begin
                  spelled.push_front(glyph_of(4'(rest % 10)));
                  rest = rest / 10;
               end while (rest != 0);
            end
         endcase
         foreach (spelled[i]) begin
            g.digit_char = spelled[i];
            g.last       = (i == spelled.size() - 1);
            pending_chars.push_back(g);
         end
      endfunction

      // Compare one response transfer with the oldest expected character.
      function void check_char(input char_type digit_char, input logic last);
         glyph_type want;
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected character %h last %b", $realtime, digit_char, last);
            return;
         end
         want = pending_chars.pop_front();
         if (digit_char !== want.digit_char || last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: character mismatch: expected %h last %b, got %h last %b",
                        $realtime, want.digit_char, want.last, digit_char, last);
         end
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block.
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   // request: value [31:0], func [33:32], zero pad [39:34]
   logic [39:0] req_tdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // response: digit_char [6:0], zero pad [7]
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   ascii_digit_board board = new();

   int req_quiet = 0;   // remaining requests sent without a gap
   int rsp_quiet = 0;   // remaining characters taken without a stall

   always #1 clock = ~clock;

   integer_to_radix_ascii i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Draw a random wait up to MAX_WAIT; now and then start a quiet stretch of zeros
   // so back-to-back transfers also get exercised.
   function automatic int draw_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0)
         quiet = $urandom_range(8, 40);
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Offer one request after a random gap and hold it until it is taken.
   // With no gap, valid simply stays high into the next transfer.
   task automatic send_request(input logic [31:0] value, input radix_type radix);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'b000000, radix, value};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(value, radix);
   endtask

   // Random value, weighted toward the spots where digit counts change.
   function automatic logic [31:0] pick_value();
      int unsigned p;
      int unsigned k;
      p = $urandom_range(0, 0);
      k = $urandom_range(0, 9);
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 999);
         1: begin
            // a power of ten or one below it
            p = 1;
            repeat (k) p = p * 10;
            return p - $urandom_range(0, 1);
         end
         2: return 32'h1 << $urandom_range(0, 31);
         3: return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom();
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Response side: stall at random, then take and check one character.
   // -------------------------------------------------------------------------
   initial begin : sink
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_char(rsp_tdata[CHAR_W-1:0], rsp_tlast);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run if neither side moves for too long.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus and final verdict.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Zero, all ones and the lone top bit in every radix; top bit set must
      // stay an unsigned magnitude.
      for (int r = 0; r < 4; r++) begin
         send_request(32'h0000_0000, radix_type'(r));
         send_request(32'hFFFF_FFFF, radix_type'(r));
         send_request(32'h8000_0000, radix_type'(r));
      end
      // Decimal digit-count boundaries.
      send_request(32'd1,          RADIX_DEC);
      send_request(32'd9,          RADIX_DEC);
      send_request(32'd10,         RADIX_DEC);
      send_request(32'd999999999,  RADIX_DEC);
      send_request(32'd1000000000, RADIX_DEC);
      send_request(32'h7FFF_FFFF,  RADIX_DEC);
      // Every hex letter, alternating bits, and a full top octal digit.
      send_request(32'hABCD_EF01,  RADIX_HEX);
      send_request(32'h1234_5678,  RADIX_HEX);
      send_request(32'hAAAA_AAAA,  RADIX_BIN);
      send_request(32'h5555_5555,  RADIX_BIN);
      send_request(32'hC000_0000,  RADIX_OCT);
      send_request(32'h3FFF_FFFF,  RADIX_OCT);

      for (int n = 0; n < RANDOM_ITEMS; n++)
         send_request(pick_value(), radix_type'($urandom_range(0, 3)));
      req_tvalid <= 1'b0;

      // Drain, then allow time for any stray extra character to show up.
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
